// ===== design/idalloc_pkg.sv =====
// shared constants and types for the identifier allocator
`default_nettype none
package idalloc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 64;
  localparam int ID_W        = 2 * WORD_W;
  localparam int COUNT_W     = 7;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/idalloc_ctrl.sv =====
// sequencer: takes one word, runs the datapath step, returns to idle
`default_nettype none
module idalloc_ctrl import idalloc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state, state_next;
  logic   accept;

  assign in_stall = rst || (state != ST_IDLE) || status.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.capture = accept;
  assign cmd.execute = (state == ST_EXEC);

endmodule
`default_nettype wire

// ===== design/idalloc_dp.sv =====
// datapath: recycle stack memory, fill count, id counter and output register
`default_nettype none
module idalloc_dp import idalloc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_status_t               status,
  input  wire logic                command,
  input  wire logic [WORD_W-1:0]   release_id_low,
  input  wire logic [WORD_W-1:0]   release_id_high,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        alloc_id_low,
  output logic [WORD_W-1:0]        alloc_id_high,
  output logic                     was_recycled,
  output logic                     release_dropped,
  output logic [COUNT_W-1:0]       recycled_count
);

  logic [ID_W-1:0]   mem [STACK_DEPTH];
  logic [ID_W-1:0]   rd_data;
  logic [ID_W-1:0]   rel_id;
  logic              cmd_q;
  logic [FILL_W-1:0] fill, fill_next, fill_dec;
  logic [ID_W-1:0]   counter, counter_inc;
  logic              pop, push;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [ID_W-1:0]   id_next;

  assign fill_dec    = fill - 1'b1;
  assign rd_addr     = fill_dec[ADDR_W-1:0];
  assign wr_addr     = fill[ADDR_W-1:0];
  assign counter_inc = counter + 1'b1;

  assign pop  = (cmd_q == CMD_ALLOC) && (fill != '0);
  assign push = (cmd_q == CMD_RELEASE) && (fill < FILL_W'(STACK_DEPTH));

  always_comb begin
    fill_next = fill;
    id_next   = '0;
    if (pop) begin
      fill_next = fill_dec;
      id_next   = rd_data;
    end else if (cmd_q == CMD_ALLOC) begin
      id_next = counter_inc;
    end else if (push) begin
      fill_next = fill + 1'b1;
    end
  end

  // top entry is read on every accept; used only when the step pops
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[rd_addr];
      cmd_q   <= command;
      rel_id  <= {release_id_high, release_id_low};
    end
    if (cmd.execute && push) begin
      mem[wr_addr] <= rel_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      counter <= '0;
    end else if (cmd.execute) begin
      fill <= fill_next;
      if (cmd_q == CMD_ALLOC && !pop) counter <= counter_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      alloc_id_low    <= id_next[WORD_W-1:0];
      alloc_id_high   <= id_next[ID_W-1:WORD_W];
      was_recycled    <= pop;
      release_dropped <= (cmd_q == CMD_RELEASE) && !push;
      recycled_count  <= COUNT_W'(fill_next);
    end
  end

  assign status.out_blocked = out_valid && out_stall;

endmodule
`default_nettype wire

// ===== design/id_allocator_with_recycle_stack.sv =====
// top level of the identifier allocator with recycle stack
//
//   port group  dir  handshake            carries
//   input       in   in_valid / in_stall  command, release_id_low, release_id_high
//   output      out  out_valid / out_stall alloc_id_low/high, was_recycled,
//                                          release_dropped, recycled_count
//
// each word passes through accept (stack top read into the memory output
// register), then the execute step that updates stack, fill and counter and
// loads the output register. the next word is taken once the output register
// is empty or draining. synchronous reset clears fill, counter and the
// output valid; stack contents are not cleared. in_stall is high in reset.
`default_nettype none
module id_allocator_with_recycle_stack import idalloc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                command,
  input  wire logic [WORD_W-1:0]   release_id_low,
  input  wire logic [WORD_W-1:0]   release_id_high,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        alloc_id_low,
  output logic [WORD_W-1:0]        alloc_id_high,
  output logic                     was_recycled,
  output logic                     release_dropped,
  output logic [COUNT_W-1:0]       recycled_count
);

  dp_cmd_t    cmd;
  dp_status_t status;

  idalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  idalloc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .command         (command),
    .release_id_low  (release_id_low),
    .release_id_high (release_id_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .alloc_id_low    (alloc_id_low),
    .alloc_id_high   (alloc_id_high),
    .was_recycled    (was_recycled),
    .release_dropped (release_dropped),
    .recycled_count  (recycled_count)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous word still executing");

  a_out_empty_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("output register occupied when execute step is due");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.execute))
    else $error("result appeared without an execute step");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_recycled) |-> !release_dropped)
    else $error("recycled and dropped flagged together");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the identifier allocator with recycle stack
`default_nettype none
module tb import idalloc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PERIOD       = 20;
  localparam int          RANDOM_WORDS = 1130;
  localparam int          QUIET_TAIL   = 150;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          WATCHDOG     = 2000;
  localparam int          DIR_ROWS     = 20;
  localparam [WORD_W-1:0] ONES         = {WORD_W{1'b1}};
  localparam [WORD_W-1:0] TOP_BIT      = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic [WORD_W-1:0]  id_lo;
    logic [WORD_W-1:0]  id_hi;
    logic               recycled;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } grant_t;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] id_lo;
    logic [WORD_W-1:0] id_hi;
    logic              fixed;
    grant_t            want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               command;
  logic [WORD_W-1:0]  release_id_low;
  logic [WORD_W-1:0]  release_id_high;
  logic               out_valid;
  logic               out_stall;
  logic [WORD_W-1:0]  alloc_id_low;
  logic [WORD_W-1:0]  alloc_id_high;
  logic               was_recycled;
  logic               release_dropped;
  logic [COUNT_W-1:0] recycled_count;

  // word tag travelling with the payload: fixed expectation or predictor
  logic               cur_fixed;
  grant_t             cur_want;

  // shadow of the allocator
  logic [WORD_W-1:0]  held_lo [STACK_DEPTH];
  logic [WORD_W-1:0]  held_hi [STACK_DEPTH];
  int unsigned        held;
  logic [ID_W-1:0]    fresh_ctr;

  grant_t             pending_grants[$];
  logic [ID_W-1:0]    last_grant;
  int                 errors;
  int                 words_in, words_out, idle_cycles;
  int                 n_fresh, n_recycled, n_release, n_dropped, max_held;
  int                 gap_pct;
  bit                 no_idle;
  bit                 hold_request;

  // extremes and error-free paths; counter wrap needs 2**128 allocations and
  // no preload exists, so it stays out of reach
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b1, '{64'd1, 64'd0, 1'b0, 1'b0, 7'd0}},
    '{CMD_ALLOC,   ONES,  ONES,  1'b1, '{64'd2, 64'd0, 1'b0, 1'b0, 7'd0}},
    '{CMD_RELEASE, ONES,  ONES,  1'b1, '{64'd0, 64'd0, 1'b0, 1'b0, 7'd1}},
    '{CMD_RELEASE, 64'h0, 64'h0, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b0, 7'd2}},
    '{CMD_ALLOC,   ONES,  ONES,  1'b1, '{64'd0, 64'd0, 1'b1, 1'b0, 7'd1}},
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b1, '{ONES,  ONES,  1'b1, 1'b0, 7'd0}},
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b1, '{64'd3, 64'd0, 1'b0, 1'b0, 7'd0}},
    '{CMD_RELEASE, 64'd1, TOP_BIT, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b0, 7'd1}},
    '{CMD_RELEASE, TOP_BIT, 64'd1, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b0, 7'd2}},
    '{CMD_ALLOC,   64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b1,
      '{TOP_BIT, 64'd1, 1'b1, 1'b0, 7'd1}},
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b1, '{64'd1, TOP_BIT, 1'b1, 1'b0, 7'd0}},
    '{CMD_RELEASE, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
    '{CMD_RELEASE, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{CMD_RELEASE, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0, '0},
    '{CMD_ALLOC,   ONES,  64'h0, 1'b0, '0},
    '{CMD_RELEASE, 64'd3, 64'd0, 1'b0, '0},
    '{CMD_ALLOC,   64'h0, ONES,  1'b0, '0},
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b0, '0},
    '{CMD_ALLOC,   64'h0, 64'h0, 1'b0, '0},
    '{CMD_ALLOC,   ONES,  ONES,  1'b0, '0}
  };

  id_allocator_with_recycle_stack uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .release_id_low  (release_id_low),
    .release_id_high (release_id_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .alloc_id_low    (alloc_id_low),
    .alloc_id_high   (alloc_id_high),
    .was_recycled    (was_recycled),
    .release_dropped (release_dropped),
    .recycled_count  (recycled_count)
  );

  always #(PERIOD/2) clk = ~clk;

  function automatic grant_t allocator_step(logic cmd, logic [WORD_W-1:0] lo,
                                            logic [WORD_W-1:0] hi);
    grant_t g;
    g = '0;
    if (cmd == CMD_ALLOC) begin
      if (held > 0) begin
        held--;
        g.id_lo    = held_lo[held];
        g.id_hi    = held_hi[held];
        g.recycled = 1'b1;
      end else begin
        fresh_ctr = fresh_ctr + 1'b1;
        g.id_lo   = fresh_ctr[WORD_W-1:0];
        g.id_hi   = fresh_ctr[ID_W-1:WORD_W];
      end
    end else if (held < STACK_DEPTH) begin
      held_lo[held] = lo;
      held_hi[held] = hi;
      held++;
    end else begin
      g.dropped = 1'b1;
    end
    g.count = COUNT_W'(held);
    return g;
  endfunction

  task automatic send_word(logic cmd, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                           logic fixed, grant_t want);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    release_id_low  <= lo;
    release_id_high <= hi;
    cur_fixed       <= fixed;
    cur_want        <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // input and output monitors, predictor hookup and watchdog
  always @(posedge clk) begin : monitor
    grant_t g;
    grant_t got;
    bit     moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        g = allocator_step(command, release_id_low, release_id_high);
        if (command == CMD_RELEASE) begin
          n_release++;
          if (g.dropped) n_dropped++;
        end else if (g.recycled) begin
          n_recycled++;
        end else begin
          n_fresh++;
        end
        if (command == CMD_ALLOC) last_grant = {g.id_hi, g.id_lo};
        if (held > max_held) max_held = held;
        pending_grants.insert(pending_grants.size(), cur_fixed ? cur_want : g);
        words_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = '{alloc_id_low, alloc_id_high, was_recycled, release_dropped, recycled_count};
        words_out++;
        moved = 1'b1;
        if (pending_grants.size() == 0) begin
          $display("%0t ns: unexpected word: expected none, got %h", $time, got);
          errors++;
        end else begin
          g = pending_grants.pop_front();
          if (got.id_lo !== g.id_lo) begin
            $display("%0t ns: alloc_id_low expected %h got %h", $time, g.id_lo, got.id_lo);
            errors++;
          end
          if (got.id_hi !== g.id_hi) begin
            $display("%0t ns: alloc_id_high expected %h got %h", $time, g.id_hi, got.id_hi);
            errors++;
          end
          if (got.recycled !== g.recycled) begin
            $display("%0t ns: was_recycled expected %b got %b", $time, g.recycled,
                     got.recycled);
            errors++;
          end
          if (got.dropped !== g.dropped) begin
            $display("%0t ns: release_dropped expected %b got %b", $time, g.dropped,
                     got.dropped);
            errors++;
          end
          if (got.count !== g.count) begin
            $display("%0t ns: recycled_count expected %0d got %0d", $time, g.count,
                     got.count);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t ns: no word moved for %0d cycles, %0d still expected", $time,
                 idle_cycles, pending_grants.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // long hold so the block backs up and stalls its input
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle) begin
        n = $urandom_range(0, 39);
        if (n < 5) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 15)) @(posedge clk);
          out_stall <= 1'b0;
        end else if (n == 5) begin
          repeat ($urandom_range(20, 100)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int              mode, run_len, sent, k, pick;
    logic            cmd;
    logic [ID_W-1:0] rel_id;
    rst             = 1'b1;
    in_valid        = 1'b0;
    command         = CMD_ALLOC;
    release_id_low  = '0;
    release_id_high = '0;
    cur_fixed       = 1'b0;
    cur_want        = '0;
    held            = 0;
    fresh_ctr       = '0;
    last_grant      = '0;
    errors          = 0;
    words_in        = 0;
    words_out       = 0;
    idle_cycles     = 0;
    n_fresh         = 0;
    n_recycled      = 0;
    n_release       = 0;
    n_dropped       = 0;
    max_held        = 0;
    gap_pct         = 0;
    no_idle         = 1'b0;
    hold_request    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_ROWS; k++)
      send_word(dir_tab[k].cmd, dir_tab[k].id_lo, dir_tab[k].id_hi, dir_tab[k].fixed,
                dir_tab[k].want);

    // bursts that fill the stack past full, drain it to empty, or mix
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mode    = $urandom_range(0, 2);
      run_len = (mode == 2) ? $urandom_range(1, 40) : $urandom_range(1, 90);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      for (k = 0; k < run_len && sent < RANDOM_WORDS; k++) begin
        if (sent >= RANDOM_WORDS - QUIET_TAIL) begin
          gap_pct = 0;
          no_idle = 1'b1;
        end
        case (mode)
          0:       cmd = ($urandom_range(0, 19) != 0) ? CMD_RELEASE : CMD_ALLOC;
          1:       cmd = ($urandom_range(0, 19) != 0) ? CMD_ALLOC : CMD_RELEASE;
          default: cmd = $urandom_range(0, 1) ? CMD_RELEASE : CMD_ALLOC;
        endcase
        pick = $urandom_range(0, 9);
        case (pick) inside
          0:       rel_id = '0;
          1:       rel_id = {ID_W{1'b1}};
          [2:3]:   rel_id = last_grant;
          default: rel_id = {$urandom, $urandom, $urandom, $urandom};
        endcase
        if (sent == 300) hold_request = 1'b1;
        send_word(cmd, rel_id[WORD_W-1:0], rel_id[ID_W-1:WORD_W], 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d words in, %0d out; %0d fresh and %0d recycled allocations",
             words_in, words_out, n_fresh, n_recycled);
    $display("tb: %0d releases, %0d dropped on a full stack; fill peaked at %0d of %0d",
             n_release, n_dropped, max_held, STACK_DEPTH);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
